// File: hdl/ecgf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecgf_pkg
// Shared constants, register map and types of the ECG channel gain and spike
// filter block.
// ----------------------------------------------------------------------------
package ecgf_pkg;

   localparam int CHAN_W      = 3;
   localparam int MASK_W      = 8;
   localparam int GAIN_W      = 24;
   localparam int THR_W       = 24;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int GAIN_CODE_W = 3;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_CHAN_EN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LO_EN   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH  = 2'd3;

   localparam logic [MASK_W-1:0] CHAN_EN_RST = 8'hFF;
   localparam logic [GAIN_W-1:0] GAIN_RST    = 24'h924924;
   localparam logic [MASK_W-1:0] LO_EN_RST   = 8'hFF;
   localparam logic [THR_W-1:0]  THRESH_RST  = 24'h400000;

   // gain codes
   localparam logic [GAIN_CODE_W-1:0] GAIN_X1     = 3'd0;
   localparam logic [GAIN_CODE_W-1:0] GAIN_X2     = 3'd1;
   localparam logic [GAIN_CODE_W-1:0] GAIN_X3     = 3'd2;
   localparam logic [GAIN_CODE_W-1:0] GAIN_X4     = 3'd3;
   localparam logic [GAIN_CODE_W-1:0] GAIN_X6     = 3'd4;
   localparam logic [GAIN_CODE_W-1:0] GAIN_X8     = 3'd5;
   localparam logic [GAIN_CODE_W-1:0] GAIN_X12    = 3'd6;
   localparam logic [GAIN_CODE_W-1:0] GAIN_X1_ALT = 3'd7;

   typedef struct packed {
      logic [CHAN_W-1:0] ch;
      logic              in_range;
      logic              enabled;
      logic              lead_off;
   } scl_ctl_type;

endpackage
`default_nettype wire

// File: hdl/ecgf_bus_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecgf_bus_if
// Valid/ready channels of the block: sample requests and filtered responses.
// ----------------------------------------------------------------------------
interface ecgf_req_if import ecgf_pkg::*; #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic [CHAN_W-1:0]             channel;
   logic signed [SAMPLE_BITS-1:0] raw_sample;
   logic                          lead_off_event;

   modport source (output valid, output channel, output raw_sample, output lead_off_event,
                   input ready);
   modport sink   (input valid, input channel, input raw_sample, input lead_off_event,
                   output ready);
endinterface

interface ecgf_rsp_if import ecgf_pkg::*; #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic [CHAN_W-1:0]             out_channel;
   logic signed [SAMPLE_BITS-1:0] out_sample;
   logic                          lead_off_status;

   modport source (output valid, output out_channel, output out_sample,
                   output lead_off_status, input ready);
   modport sink   (input valid, input out_channel, input out_sample,
                   input lead_off_status, output ready);
endinterface
`default_nettype wire

// File: hdl/ecgf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecgf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ecgf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: hdl/ecgf_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecgf_scale
// Gain rescale pipeline: magnitude, reciprocal multiply by 1/3, gain select,
// sign restore and saturation over three register stages.
// ----------------------------------------------------------------------------
module ecgf_scale import ecgf_pkg::*; #(
   parameter int NUM_CHANNELS = 8,
   parameter int SAMPLE_BITS  = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   ecgf_req_if.sink                           req,
   input  wire logic [MASK_W-1:0]             chan_en_mask,
   input  wire logic [GAIN_W-1:0]             gain_codes,
   input  wire logic [MASK_W-1:0]             lo_en_mask,
   output logic                               sc_valid,
   input  wire logic                          sc_ready,
   output scl_ctl_type                        sc_ctl,
   output logic signed [SAMPLE_BITS-1:0]      sc_sample
);

   localparam int SB = SAMPLE_BITS;
   localparam int PW = 2 * SB;
   localparam logic [63:0] RECIP_W = ((64'd1 << (SB + 1)) + 64'd2) / 64'd3;
   localparam logic [SB-1:0] RECIP = RECIP_W[SB-1:0];
   localparam logic [SB-1:0] SAT_MAX = {1'b0, {(SB - 1){1'b1}}};
   localparam logic [SB-1:0] SAT_MIN = {1'b1, {(SB - 1){1'b0}}};

   // stage 1
   logic                   s1_v_ff;
   scl_ctl_type            s1_ctl_ff, s1_ctl_in;
   logic [GAIN_CODE_W-1:0] s1_code_ff, s1_code_in;
   logic                   s1_neg_ff;
   logic [SB-1:0]          s1_mag_ff, s1_mag_in;
   logic                   in_range;
   // stage 2
   logic                   s2_v_ff;
   scl_ctl_type            s2_ctl_ff;
   logic [GAIN_CODE_W-1:0] s2_code_ff;
   logic                   s2_neg_ff;
   logic [SB-1:0]          s2_mag_ff;
   logic [PW-1:0]          s2_prod_ff, s2_prod_in;
   // stage 3
   logic                   s3_v_ff;
   scl_ctl_type            s3_ctl_ff;
   logic [SB-1:0]          s3_sample_ff, s3_sample_in;

   logic                   en1, en2, en3;
   logic [SB-2:0]          quot;
   logic [SB+1:0]          rem_wide;
   logic [1:0]             rem;
   logic [SB:0]            quot_x, mag_x, scaled;
   logic [SB+1:0]          signed_val;

   assign en3       = !s3_v_ff || sc_ready;
   assign en2       = !s2_v_ff || en3;
   assign en1       = !s1_v_ff || en2;
   assign req.ready = en1;

   // stage 1: decode and magnitude
   always_comb begin
      in_range           = (32'(req.channel) < 32'(NUM_CHANNELS));
      s1_ctl_in.ch       = req.channel;
      s1_ctl_in.in_range = in_range;
      s1_ctl_in.enabled  = in_range && chan_en_mask[req.channel];
      s1_ctl_in.lead_off = in_range && req.lead_off_event && lo_en_mask[req.channel];
      s1_code_in         = gain_codes[5'(req.channel) * 5'd3 +: GAIN_CODE_W];
      s1_mag_in          = req.raw_sample[SB-1] ? (~req.raw_sample + SB'(1))
                                                : req.raw_sample;
   end

   // stage 2: multiply by reciprocal of 3
   assign s2_prod_in = PW'(s1_mag_ff) * PW'(RECIP);

   // stage 3: gain select, sign and saturation
   always_comb begin
      quot     = s2_prod_ff[PW-1:SB+1];
      rem_wide = (SB + 2)'(s2_mag_ff) - ((SB + 2)'(quot) << 1) - (SB + 2)'(quot);
      rem      = rem_wide[1:0];
      quot_x   = (SB + 1)'(quot);
      mag_x    = (SB + 1)'(s2_mag_ff);
      case (s2_code_ff) inside
         GAIN_X1, GAIN_X1_ALT: scaled = quot_x >> 1;
         GAIN_X2:              scaled = quot_x;
         GAIN_X3:              scaled = mag_x >> 1;
         GAIN_X4:              scaled = (quot_x << 1) + (SB + 1)'(rem == 2'd2);
         GAIN_X6:              scaled = mag_x;
         GAIN_X8:              scaled = (quot_x << 2) + (SB + 1)'(rem);
         GAIN_X12:             scaled = mag_x << 1;
         default:              scaled = '0;
      endcase
      signed_val = s2_neg_ff ? ((SB + 2)'(0) - (SB + 2)'(scaled)) : (SB + 2)'(scaled);
      if ((signed_val[SB+1:SB-1] == 3'b000) || (signed_val[SB+1:SB-1] == 3'b111)) begin
         s3_sample_in = signed_val[SB-1:0];
      end else if (signed_val[SB+1]) begin
         s3_sample_in = SAT_MIN;
      end else begin
         s3_sample_in = SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         if (en1) begin
            s1_v_ff <= req.valid;
         end
         if (en2) begin
            s2_v_ff <= s1_v_ff;
         end
         if (en3) begin
            s3_v_ff <= s2_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && req.valid) begin
         s1_ctl_ff  <= s1_ctl_in;
         s1_code_ff <= s1_code_in;
         s1_neg_ff  <= req.raw_sample[SB-1];
         s1_mag_ff  <= s1_mag_in;
      end
      if (en2 && s1_v_ff) begin
         s2_ctl_ff  <= s1_ctl_ff;
         s2_code_ff <= s1_code_ff;
         s2_neg_ff  <= s1_neg_ff;
         s2_mag_ff  <= s1_mag_ff;
         s2_prod_ff <= s2_prod_in;
      end
      if (en3 && s2_v_ff) begin
         s3_ctl_ff    <= s2_ctl_ff;
         s3_sample_ff <= s3_sample_in;
      end
   end

   assign sc_valid  = s3_v_ff;
   assign sc_ctl    = s3_ctl_ff;
   assign sc_sample = s3_sample_ff;

endmodule
`default_nettype wire

// File: hdl/ecgf_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecgf_filter
// Spike filter around the previous-sample RAM: read, compare, write back with
// forwarding of the last write, lead-off forcing and the response register.
// ----------------------------------------------------------------------------
module ecgf_filter import ecgf_pkg::*; #(
   parameter int NUM_CHANNELS = 8,
   parameter int SAMPLE_BITS  = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          sc_valid,
   output logic                               sc_ready,
   input  wire scl_ctl_type                   sc_ctl,
   input  wire logic signed [SAMPLE_BITS-1:0] sc_sample,
   input  wire logic [THR_W-1:0]              threshold,
   ecgf_rsp_if.source                         rsp
);

   localparam int SB    = SAMPLE_BITS;
   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CW    = ((SB + 1) > THR_W) ? (SB + 1) : THR_W;
   localparam logic [SB-1:0] SAT_MAX = {1'b0, {(SB - 1){1'b1}}};

   function automatic logic [IDX_W-1:0] to_idx(input logic [CHAN_W-1:0] c);
      logic [7:0] w;
      w = 8'(c);
      return w[IDX_W-1:0];
   endfunction

   logic                     b_v_ff;
   scl_ctl_type              b_ctl_ff;
   logic signed [SB-1:0]     b_sample_ff;
   logic [NUM_CHANNELS-1:0]  vld_ff;
   logic                     fwd_v_ff;
   logic [IDX_W-1:0]         fwd_idx_ff;
   logic [SB-1:0]            fwd_val_ff;
   logic                     out_v_ff;
   logic [CHAN_W-1:0]        out_ch_ff;
   logic [SB-1:0]            out_sample_ff, out_sample_in;
   logic                     out_lo_ff;

   logic                     en_out, en_b, retire;
   logic [IDX_W-1:0]         b_idx, raddr;
   logic [SB-1:0]            ram_rdata;
   logic                     ram_we;
   logic signed [SB-1:0]     prev;
   logic signed [SB:0]       diff;
   logic [SB:0]              abs_diff;
   logic                     spike;
   logic [SB-1:0]            kept;

   assign en_out   = !out_v_ff || rsp.ready;
   assign en_b     = !b_v_ff || en_out;
   assign sc_ready = en_b;
   assign retire   = b_v_ff && en_out;
   assign b_idx    = to_idx(b_ctl_ff.ch);
   assign raddr    = en_b ? to_idx(sc_ctl.ch) : b_idx;
   assign ram_we   = retire && b_ctl_ff.enabled;

   ecgf_ram #(
      .WIDTH (SB),
      .DEPTH (NUM_CHANNELS)
   ) u_prev_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (b_idx),
      .wdata (kept),
      .raddr (raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      if (fwd_v_ff && (fwd_idx_ff == b_idx)) begin
         prev = signed'(fwd_val_ff);
      end else if (b_ctl_ff.enabled && vld_ff[b_idx]) begin
         prev = signed'(ram_rdata);
      end else begin
         prev = '0;
      end
      diff     = (SB + 1)'(b_sample_ff) - (SB + 1)'(prev);
      abs_diff = diff[SB] ? (SB + 1)'(-diff) : (SB + 1)'(diff);
      spike    = CW'(abs_diff) > CW'(threshold);
      kept     = spike ? prev : b_sample_ff;
      if (b_ctl_ff.lead_off) begin
         out_sample_in = SAT_MAX;
      end else if (b_ctl_ff.enabled) begin
         out_sample_in = kept;
      end else begin
         out_sample_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff   <= 1'b0;
         out_v_ff <= 1'b0;
         vld_ff   <= '0;
         fwd_v_ff <= 1'b0;
      end else begin
         if (en_b) begin
            b_v_ff <= sc_valid;
         end
         if (en_out) begin
            out_v_ff <= b_v_ff;
         end
         if (ram_we) begin
            vld_ff[b_idx] <= 1'b1;
            fwd_v_ff      <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_b && sc_valid) begin
         b_ctl_ff    <= sc_ctl;
         b_sample_ff <= sc_sample;
      end
      if (ram_we) begin
         fwd_idx_ff <= b_idx;
         fwd_val_ff <= kept;
      end
      if (retire) begin
         out_ch_ff     <= b_ctl_ff.ch;
         out_sample_ff <= out_sample_in;
         out_lo_ff     <= b_ctl_ff.lead_off;
      end
   end

   assign rsp.valid           = out_v_ff;
   assign rsp.out_channel     = out_ch_ff;
   assign rsp.out_sample      = out_sample_ff;
   assign rsp.lead_off_status = out_lo_ff;

   a_lead_off_rail: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && out_lo_ff) |-> (out_sample_ff == SAT_MAX))
      else $error("lead-off response not at positive rail");

   a_no_write_on_stall: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp.ready) |-> !ram_we)
      else $error("history written while response stalled");

   a_write_marks_valid: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> vld_ff[$past(b_idx)])
      else $error("written entry not marked valid");

   a_write_forwarded: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> (fwd_v_ff && (fwd_idx_ff == $past(b_idx)) && (fwd_val_ff == $past(kept))))
      else $error("forwarding register missed last write");

endmodule
`default_nettype wire

// File: hdl/ecg_channel_gain_spike_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecg_channel_gain_spike_filter
// Per-channel gain rescale, saturation, spike suppression and lead-off forcing
// of interleaved ECG converter samples.
//
// Each req transaction carries a channel number, a signed raw sample taken at
// gain 6 and a lead-off flag. Each one yields exactly one rsp transaction,
// in order: the channel, the rescaled, saturated and spike-filtered sample
// (or the positive rail on an enabled lead-off), and the lead-off status.
// One transaction is accepted per cycle unless rsp stalls have filled the
// pipeline; the previous-sample RAM is read and written once per cycle, and the
// last write is forwarded to the next read. Each request passes the scale
// stages, the filter and response registers; up to 5 transactions are in flight.
// The csr port writes four registers (channel enable, gain codes, lead-off
// enable, spike threshold); write only while no transaction is in flight.
// Reset restores register defaults and marks every channel history as zero
// at once; no clearing pass is needed.
// When rsp is stalled the response register holds and the pipeline keeps
// filling its empty stages, then req_bus.ready drops.
// ----------------------------------------------------------------------------
module ecg_channel_gain_spike_filter import ecgf_pkg::*; #(
   parameter int NUM_CHANNELS = 8,
   parameter int SAMPLE_BITS  = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   ecgf_req_if.sink                   req_bus,
   ecgf_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [MASK_W-1:0] chan_en_ff, chan_en_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [MASK_W-1:0] lo_en_ff, lo_en_in;
   logic [THR_W-1:0]  thresh_ff, thresh_in;

   logic                          sc_valid;
   logic                          sc_ready;
   scl_ctl_type                   sc_ctl;
   logic signed [SAMPLE_BITS-1:0] sc_sample;

   always_comb begin
      chan_en_in = chan_en_ff;
      gain_in    = gain_ff;
      lo_en_in   = lo_en_ff;
      thresh_in  = thresh_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CHAN_EN: chan_en_in = csr_wdata[MASK_W-1:0];
            CSR_GAIN:    gain_in    = csr_wdata[GAIN_W-1:0];
            CSR_LO_EN:   lo_en_in   = csr_wdata[MASK_W-1:0];
            CSR_THRESH:  thresh_in  = csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_en_ff <= CHAN_EN_RST;
         gain_ff    <= GAIN_RST;
         lo_en_ff   <= LO_EN_RST;
         thresh_ff  <= THRESH_RST;
      end else begin
         chan_en_ff <= chan_en_in;
         gain_ff    <= gain_in;
         lo_en_ff   <= lo_en_in;
         thresh_ff  <= thresh_in;
      end
   end

   ecgf_scale #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_scale (
      .clock        (clock),
      .reset        (reset),
      .req          (req_bus),
      .chan_en_mask (chan_en_ff),
      .gain_codes   (gain_ff),
      .lo_en_mask   (lo_en_ff),
      .sc_valid     (sc_valid),
      .sc_ready     (sc_ready),
      .sc_ctl       (sc_ctl),
      .sc_sample    (sc_sample)
   );

   ecgf_filter #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_filter (
      .clock     (clock),
      .reset     (reset),
      .sc_valid  (sc_valid),
      .sc_ready  (sc_ready),
      .sc_ctl    (sc_ctl),
      .sc_sample (sc_sample),
      .threshold (thresh_ff),
      .rsp       (rsp_bus)
   );

endmodule
`default_nettype wire
